// ===== rtl/dnle_pkg.sv =====
// Shared types and constants for the DNS name label encoder.
package dnle_pkg;

    localparam int LEN_W     = 6;
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic             term;
        logic             ovf;
        logic             bank;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef struct packed {
        logic [7:0] wbyte;
        logic       last;
        logic       ovf;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_CHAR = 4'b0100,
        S_TERM = 4'b1000
    } back_state_t;

endpackage

// ===== rtl/dnle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dnle_fifo.sv =====
// Small register FIFO with first-word fall-through and occupancy count.
module dnle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/dnle_front.sv =====
// Front end: accepts characters, fills the label store, issues emit commands.
module dnle_front #(
    parameter int MAX_LABEL = 63,
    parameter int IDX_W     = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         ch,
    input  logic               end_of_name,
    output logic               st_we,
    output logic [IDX_W:0]     st_waddr,
    output logic [7:0]         st_wdata,
    output logic               cmd_push,
    output dnle_pkg::cmd_t     cmd,
    input  logic               cmd_full,
    input  dnle_pkg::rel_t     rel
);

    import dnle_pkg::*;

    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_next;
    logic             flushed_reg;
    logic             flushed_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             wbank_reg;
    logic             wbank_next;
    logic [1:0]       busy_reg;
    logic [1:0]       busy_next;
    logic             accept;
    logic             pending;
    logic [LEN_W-1:0] cnt_inc;

    assign full     = cmd_full || busy_reg[wbank_reg];
    assign accept   = push && !full;
    assign pending  = (cnt_reg != '0) && !flushed_reg;
    assign cnt_inc  = cnt_reg + LEN_W'(1);
    assign st_waddr = {wbank_reg, cnt_reg[IDX_W-1:0]};
    assign st_wdata = ch;

    always_comb
    begin
        cnt_next     = cnt_reg;
        flushed_next = flushed_reg;
        ovf_next     = ovf_reg;
        wbank_next   = wbank_reg;
        busy_next    = busy_reg;
        st_we        = 1'b0;
        cmd_push     = 1'b0;
        cmd.term     = 1'b0;
        cmd.ovf      = ovf_reg;
        cmd.bank     = wbank_reg;
        cmd.len      = cnt_reg;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            priority if (end_of_name)
            begin
                cmd_push = 1'b1;
                cmd.term = 1'b1;
                if (pending)
                begin
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                end
                else
                begin
                    cmd.len = '0;
                end
                cnt_next     = '0;
                flushed_next = 1'b0;
                ovf_next     = 1'b0;
            end
            else if (ch == DOT_CHAR)
            begin
                if (pending)
                begin
                    cmd_push             = 1'b1;
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                end
                cnt_next     = '0;
                flushed_next = 1'b0;
            end
            else if (flushed_reg)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                st_we    = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc == LEN_W'(MAX_LABEL))
                begin
                    cmd_push             = 1'b1;
                    cmd.len              = cnt_inc;
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                    cnt_next             = '0;
                    flushed_next         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            flushed_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            wbank_reg   <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            flushed_reg <= flushed_next;
            ovf_reg     <= ovf_next;
            wbank_reg   <= wbank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

// ===== rtl/dnle_back.sv =====
// Back end: runs emit commands, reads the label store, queues wire bytes.
module dnle_back #(
    parameter int IDX_W = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  dnle_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic [IDX_W:0] st_raddr,
    input  logic [7:0]     st_rdata,
    output dnle_pkg::rel_t rel,
    output logic           empty,
    input  logic           pop,
    output dnle_pkg::out_t head
);

    import dnle_pkg::*;

    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    back_state_t      state_reg;
    back_state_t      state_next;
    cmd_t             cur_reg;
    cmd_t             cur_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             iss_valid_reg;
    logic             iss_valid_next;
    logic             iss_ram_reg;
    logic             iss_ram_next;
    out_t             iss_item_reg;
    out_t             iss_item_next;
    logic [OCNT_W-1:0] out_count;
    logic             out_full;
    logic             can_issue;
    logic             last_char;
    out_t             out_wdata;

    assign can_issue = ({1'b0, out_count} + (OCNT_W + 1)'(iss_valid_reg))
                       < (OCNT_W + 1)'(OUT_DEPTH);
    assign last_char = ((LEN_W'(idx_reg) + LEN_W'(1)) == cur_reg.len);
    assign st_raddr  = {cur_reg.bank, idx_reg};
    assign out_wdata = iss_ram_reg ? out_t'{wbyte: st_rdata, last: 1'b0, ovf: 1'b0}
                                   : iss_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        iss_valid_next = 1'b0;
        iss_ram_next   = 1'b0;
        iss_item_next  = '{wbyte: 8'h00, last: 1'b0, ovf: 1'b0};
        cmd_pop        = 1'b0;
        rel.valid      = 1'b0;
        rel.bank       = cur_reg.bank;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    idx_next   = '0;
                    state_next = (cmd.len != '0) ? S_LEN : S_TERM;
                end
            end
            S_LEN:
            begin
                if (can_issue)
                begin
                    iss_valid_next      = 1'b1;
                    iss_item_next.wbyte = 8'(cur_reg.len);
                    state_next          = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (can_issue)
                begin
                    iss_valid_next = 1'b1;
                    iss_ram_next   = 1'b1;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (last_char)
                    begin
                        rel.valid  = 1'b1;
                        state_next = cur_reg.term ? S_TERM : S_IDLE;
                    end
                end
            end
            S_TERM:
            begin
                if (can_issue)
                begin
                    iss_valid_next     = 1'b1;
                    iss_item_next.last = 1'b1;
                    iss_item_next.ovf  = cur_reg.ovf;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_valid_reg <= iss_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        iss_ram_reg  <= iss_ram_next;
        iss_item_reg <= iss_item_next;
    end

    dnle_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (iss_valid_reg),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (head),
        .empty (empty),
        .count (out_count)
    );

    logic unused_full;
    assign unused_full = out_full;

endmodule

// ===== rtl/dns_name_label_encoder.sv =====
// Top level of the DNS name label encoder.
//
// Input queue: one character per item on ch, or an end item with end_of_name
// set; an item is taken on a clock edge with push high and full low.
// Output queue: wire bytes leave as items on out_byte, last, label_overflow;
// the oldest is shown while empty is low and is taken with pop high.
// Characters are held in a two-bank label store; a dot after a non-empty
// label, an end item or a label reaching MAX_LABEL characters queues an emit
// command for the back end. Input rate is one item per cycle while the write
// bank is free and the command queue has room; full rises while both banks
// hold labels still being emitted or the command queue is full. Outside
// command fetch the back end emits one byte per cycle while the output queue
// has room: length byte, a store read per character, terminator at name end.
// Reset clears all control state; the output queue empties and no reset of the
// label store is needed. When the receiver stalls, the 4-entry output queue
// fills, then the back end halts, then the command queue and full back up.
module dns_name_label_encoder #(
    parameter int MAX_LABEL = 63
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       end_of_name,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       label_overflow
);

    import dnle_pkg::*;

    localparam int IDX_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int ST_DEPTH = 2 << IDX_W;

    logic             st_we;
    logic [IDX_W:0]   st_waddr;
    logic [7:0]       st_wdata;
    logic [IDX_W:0]   st_raddr;
    logic [7:0]       st_rdata;
    logic             cmd_push;
    cmd_t             cmd_in;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    cmd_t             cmd_head;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    rel_t             rel;
    out_t             head;
    logic             unused_cnt;

    assign out_byte       = head.wbyte;
    assign last           = head.last;
    assign label_overflow = head.ovf;
    assign unused_cnt     = ^cmd_count;

    dnle_front #(
        .MAX_LABEL (MAX_LABEL),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .end_of_name (end_of_name),
        .st_we       (st_we),
        .st_waddr    (st_waddr),
        .st_wdata    (st_wdata),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .cmd_full    (cmd_full),
        .rel         (rel)
    );

    dnle_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_head),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    dnle_ram #(
        .WIDTH (8),
        .DEPTH (ST_DEPTH)
    ) u_label_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dnle_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .st_raddr  (st_raddr),
        .st_rdata  (st_rdata),
        .rel       (rel),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

endmodule
